// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl of the timer table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, suspended while reset is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// condition that must never be seen on a rising edge of clk
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/core/pitt_pkg.sv =====
// types and constants of the periodic interval timer table
package pitt_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

	localparam int PERIOD_W = 31;
	localparam int TIME_W   = 32;
	localparam int ENTRY_W  = PERIOD_W + TIME_W;

	localparam logic [1:0] MODE_POLL  = 2'd0;
	localparam logic [1:0] MODE_SET   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [2:0] KIND_SET_OK  = 3'd0;
	localparam logic [2:0] KIND_FULL    = 3'd1;
	localparam logic [2:0] KIND_CLEARED = 3'd2;
	localparam logic [2:0] KIND_FIRED   = 3'd3;
	localparam logic [2:0] KIND_NONE    = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [5:0] slot;
	} res_t;

endpackage

// ===== rtl/core/pitt_if.sv =====
// channel interfaces: command items in, result items out
interface pitt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] now;
	logic [30:0] period_ms;
	logic [5:0]  slot_index;
	logic        link_up;

	modport source (output valid, mode, now, period_ms, slot_index, link_up, input ready);
	modport sink (input valid, mode, now, period_ms, slot_index, link_up, output ready);
endinterface

interface pitt_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [5:0] slot_out;
	logic       last;

	modport source (output valid, kind, slot_out, last, input ready);
	modport sink (input valid, kind, slot_out, last, output ready);
endinterface

// ===== rtl/core/pitt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module pitt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/periodic_interval_timer_table_core.sv =====
// timer table core: slot allocation, clearing and the poll walk over the slot ram
//
//  channel  | dir | payload                                     | transfer
//  ---------+-----+---------------------------------------------+-----------------
//  in_ch    | in  | mode, now, period_ms, slot_index, link_up   | valid & ready
//  out_ch   | out | kind, slot_out, last                        | valid & ready
//
// set, an in-range clear and a poll with the link down go through decode, then hand-off
// poll with the link up walks the slot ram one slot a cycle unless a fire stalls it
// the registered ram read sets the walk; a fire waits on a stalled output
// slot_active flops clear on reset; period and last-fire time live in ram, no clear
// one item at a time: in_ch is ready only while no item is in progress
module periodic_interval_timer_table_core
	import pitt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	pitt_in_if.sink    in_ch,
	pitt_out_if.source out_ch
);

`include "assert_macros.svh"

	state_t state_q, state_d;

	logic [SLOT_COUNT-1:0] slot_active_q, active_d;
	logic [TIME_W-1:0]     now_q;

	logic [CNT_W-1:0]  walk_idx_q;
	logic [SLOT_W-1:0] chk_idx_s1;
	logic              chk_valid_s1;

	res_t pend_q, pend_d;
	logic pend_valid_q, pend_valid_d;

	logic out_valid_q;
	res_t out_res_q;
	logic out_last_q;
	logic out_load, out_last_d, out_free;

	logic               ram_we;
	logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	logic [PERIOD_W-1:0] rd_period;
	logic [TIME_W-1:0]   rd_last, elapsed;

	logic accept, walk_done, fire, stall, walk_adv;
	logic found;
	logic [SLOT_W-1:0] free_idx;
	logic in_range;

	pitt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_period = ram_rdata[ENTRY_W-1:TIME_W];
	assign rd_last   = ram_rdata[TIME_W-1:0];
	assign elapsed   = now_q - rd_last;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_range = {1'b0, in_ch.slot_index} < 7'(SLOT_COUNT);

	assign fire = (state_q == ST_WALK) && chk_valid_s1 && slot_active_q[chk_idx_s1]
		&& (elapsed > {1'b0, rd_period});
	// an earlier fire still waits in pend and the output register is taken
	assign stall     = fire && pend_valid_q && !out_free;
	assign walk_adv  = (state_q == ST_WALK) && !stall;
	assign walk_done = (walk_idx_q == CNT_W'(SLOT_COUNT)) && !chk_valid_s1;

	// lowest free slot
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!slot_active_q[i]) begin
				found    = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		active_d     = slot_active_q;
		pend_d       = pend_q;
		pend_valid_d = pend_valid_q;
		out_load     = 1'b0;
		out_last_d   = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = chk_idx_s1;
		ram_wdata    = {rd_period, now_q};
		ram_raddr    = stall ? chk_idx_s1 : walk_idx_q[SLOT_W-1:0];

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_ch.mode)
						MODE_POLL: begin
							if (in_ch.link_up) begin
								state_d = ST_WALK;
							end else begin
								pend_d       = '{kind: KIND_NONE, slot: '0};
								pend_valid_d = 1'b1;
								state_d      = ST_FLUSH;
							end
						end
						MODE_SET: begin
							if (found) begin
								active_d[free_idx] = 1'b1;
								ram_we    = 1'b1;
								ram_waddr = free_idx;
								ram_wdata = {in_ch.period_ms, in_ch.now};
								pend_d    = '{kind: KIND_SET_OK, slot: 6'(free_idx)};
							end else begin
								pend_d = '{kind: KIND_FULL, slot: '0};
							end
							pend_valid_d = 1'b1;
							state_d      = ST_FLUSH;
						end
						MODE_CLEAR: begin
							if (in_range) begin
								active_d[in_ch.slot_index[SLOT_W-1:0]] = 1'b0;
								pend_d       = '{kind: KIND_CLEARED, slot: in_ch.slot_index};
								pend_valid_d = 1'b1;
								state_d      = ST_FLUSH;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				if (fire && !stall) begin
					ram_we = 1'b1;
					// previous fire is not the final one, send it on
					if (pend_valid_q) begin
						out_load = 1'b1;
					end
					pend_d       = '{kind: KIND_FIRED, slot: 6'(chk_idx_s1)};
					pend_valid_d = 1'b1;
				end else if (walk_done) begin
					if (!pend_valid_q) begin
						pend_d = '{kind: KIND_NONE, slot: '0};
					end
					pend_valid_d = 1'b1;
					state_d      = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_last_d   = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			slot_active_q <= '0;
			pend_valid_q  <= 1'b0;
			chk_valid_s1  <= 1'b0;
			walk_idx_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			slot_active_q <= active_d;
			pend_valid_q  <= pend_valid_d;
			if (accept) begin
				walk_idx_q   <= '0;
				chk_valid_s1 <= 1'b0;
			end else if (walk_adv) begin
				chk_valid_s1 <= (walk_idx_q != CNT_W'(SLOT_COUNT));
				if (walk_idx_q != CNT_W'(SLOT_COUNT)) begin
					walk_idx_q <= walk_idx_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (accept) begin
			now_q <= in_ch.now;
		end
		if (walk_adv) begin
			chk_idx_s1 <= walk_idx_q[SLOT_W-1:0];
		end
		if (out_load) begin
			out_res_q  <= pend_q;
			out_last_q <= out_last_d;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.kind     = out_res_q.kind;
	assign out_ch.slot_out = out_res_q.slot;
	assign out_ch.last     = out_last_q;

	`ASSERT_CLK(a_flush_has_result, (state_q == ST_FLUSH) |-> pend_valid_q,
		"hand-off state without a pending result")
	`ASSERT_CLK(a_walk_write_active, (ram_we && state_q == ST_WALK) |-> slot_active_q[chk_idx_s1],
		"poll walk rewrote an inactive slot")
	`ASSERT_CLK(a_stall_holds_slot, stall |=> (chk_valid_s1 && $stable(chk_idx_s1)),
		"stalled walk lost the slot under check")
	`ASSERT_NEVER(a_walk_pend_kind,
		(state_q == ST_WALK) && pend_valid_q && (pend_q.kind != KIND_FIRED),
		"non-fire result pending during poll walk")

endmodule
